// ===== sv/v3a_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector ALU package
// Shared types, constants and helper functions for the three-component
// vector ALU core.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQ_STAGES     = 32;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_NEG    = 4'd2,
    CMD_CROSS  = 4'd3,
    CMD_DOT    = 4'd4,
    CMD_MAG    = 4'd5,
    CMD_MAGSQ  = 4'd6,
    CMD_DIST   = 4'd7,
    CMD_DISTSQ = 4'd8,
    CMD_NORM   = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [32:0] sum;
    logic signed [32:0] dif;
    logic signed [32:0] neg;
    logic [31:0]        u;
    logic               big;
    logic [31:0]        m;
    logic               a_neg;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
  } lane_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [2:0][31:0] vec;
    logic [31:0]      scal;
    logic             sat;
    logic             zero;
    logic             big;
    logic [2:0][31:0] mn;
    logic [2:0]       neg;
  } item_t;

  function automatic logic [32:0] sat32(input logic signed [67:0] v);
    logic [32:0] res;
    if (v > 68'sd2147483647) begin
      res = {1'b1, S32_MAX};
    end else if (v < -68'sd2147483648) begin
      res = {1'b1, S32_MIN};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  n;
    x = v;
    n = '0;
    if (x[31:16] == '0) begin
      n[4] = 1'b1;
      x = x << 16;
    end
    if (x[31:24] == '0) begin
      n[3] = 1'b1;
      x = x << 8;
    end
    if (x[31:28] == '0) begin
      n[2] = 1'b1;
      x = x << 4;
    end
    if (x[31:30] == '0) begin
      n[1] = 1'b1;
      x = x << 2;
    end
    if (x[31] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

// ===== sv/vector3_alu_core.sv =====
// ----------------------------------------------------------------------------
// Three-component vector ALU
// Add, subtract, negate, cross, dot, magnitude, distance and normalize on
// signed fixed-point vectors, with saturation and status.
// Throughput: one word per cycle while the output is not stalled, set by the pipelined root and divider.
// The 32-stage square root and FRAC_BITS+2 divider stages set the depth.
// Reset clears the valid bits of every stage; the datapath is not reset.
// ----------------------------------------------------------------------------
module vector3_alu_core #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_scalar_out,
  output logic [1:0]         out_status
);
  import v3a_pkg::*;

  localparam int DIV_STAGES = FRAC_BITS + 2;
  localparam logic signed [67:0] HALF_S = 68'sd1 <<< (FRAC_BITS - 1);
  localparam logic [64:0]        HALF_U = 65'd1 << (FRAC_BITS - 1);

  logic                   adv;
  logic                   a_vld_r;
  cmd_t                   a_cmd_r;
  logic signed [31:0]     av_r [3];
  logic signed [31:0]     bv_r [3];
  lane_t                  lane_b [3];
  logic [63:0]            sq_d [3];
  logic                   b_vld_r;
  cmd_t                   b_cmd_r;
  item_t                  item_c;
  logic [31:0]            sq_op_c [3];
  logic                   c_vld_r;
  item_t                  c_item_r;
  logic [31:0]            sq_op_r [3];
  logic                   d_vld_r;
  item_t                  d_item_r;
  item_t                  item_e;
  logic [63:0]            sq_sum;
  logic                   e_vld_r;
  item_t                  e_item_r;
  logic [63:0]            e_sq_r;
  logic [31:0]            sq_root;
  logic [33:0]            sq_rem;
  logic                   q_vld_r [SQ_STAGES];
  item_t                  q_item_r [SQ_STAGES];
  item_t                  item_f;
  logic                   f_vld_r;
  item_t                  f_item_r;
  logic [31:0]            f_len_r;
  logic [DIV_STAGES-1:0]  quo [3];
  logic                   g_vld_r [DIV_STAGES];
  item_t                  g_item_r [DIV_STAGES];
  logic                   out_valid_r;
  logic [2:0][31:0]       out_vec_r;
  logic [2:0][31:0]       out_vec_nxt;
  logic [31:0]            out_scal_r;
  status_t                out_status_r;
  status_t                out_status_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd_r <= cmd_t'(in_cmd);
      av_r[0] <= in_a_x;
      av_r[1] <= in_a_y;
      av_r[2] <= in_a_z;
      bv_r[0] <= in_b_x;
      bv_r[1] <= in_b_y;
      bv_r[2] <= in_b_z;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    v3a_lane u_lane (
      .clk   (clk),
      .en    (adv),
      .cmd   (a_cmd_r),
      .a_i   (av_r[i]),
      .b_i   (bv_r[i]),
      .a_j   (av_r[J]),
      .a_k   (av_r[K]),
      .b_j   (bv_r[J]),
      .b_k   (bv_r[K]),
      .sq_op (sq_op_r[i]),
      .res   (lane_b[i]),
      .sq    (sq_d[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_cmd_r <= a_cmd_r;
    end
  end

  // Merge of the lane results: saturated vector results, dot product, the
  // common normalize shift and the square-root operands.
  always_comb begin
    logic [31:0]        mx;
    logic [31:0]        mx_m1;
    logic [4:0]         sh;
    logic signed [67:0] t;
    logic [32:0]        sv;
    logic               big_any;
    item_c     = '0;
    item_c.cmd = b_cmd_r;
    mx = lane_b[0].m;
    if (lane_b[1].m > mx) begin
      mx = lane_b[1].m;
    end
    if (lane_b[2].m > mx) begin
      mx = lane_b[2].m;
    end
    mx_m1   = mx - 32'd1;
    sh      = lzc32({mx_m1[30:0], 1'b1});
    big_any = lane_b[0].big || lane_b[1].big || lane_b[2].big;
    t  = '0;
    sv = '0;
    for (int i = 0; i < 3; i++) begin
      item_c.neg[i] = lane_b[i].a_neg;
      item_c.mn[i]  = lane_b[i].m << sh;
    end
    case (b_cmd_r)
      CMD_ADD: begin
        for (int i = 0; i < 3; i++) begin
          sv = sat32(68'(lane_b[i].sum));
          item_c.vec[i] = sv[31:0];
          item_c.sat    = item_c.sat | sv[32];
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < 3; i++) begin
          sv = sat32(68'(lane_b[i].dif));
          item_c.vec[i] = sv[31:0];
          item_c.sat    = item_c.sat | sv[32];
        end
      end
      CMD_NEG: begin
        for (int i = 0; i < 3; i++) begin
          sv = sat32(68'(lane_b[i].neg));
          item_c.vec[i] = sv[31:0];
          item_c.sat    = item_c.sat | sv[32];
        end
      end
      CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          t  = (68'(lane_b[i].p1) - 68'(lane_b[i].p2) + HALF_S) >>> FRAC_BITS;
          sv = sat32(t);
          item_c.vec[i] = sv[31:0];
          item_c.sat    = item_c.sat | sv[32];
        end
      end
      CMD_DOT: begin
        t  = (68'(lane_b[0].p1) + 68'(lane_b[1].p1) + 68'(lane_b[2].p1) + HALF_S)
             >>> FRAC_BITS;
        sv = sat32(t);
        item_c.scal = sv[31:0];
        item_c.sat  = sv[32];
      end
      CMD_DIST, CMD_DISTSQ: begin
        item_c.big = big_any;
        if (big_any) begin
          item_c.scal = S32_MAX;
          item_c.sat  = 1'b1;
        end
      end
      CMD_NORM: begin
        item_c.zero = (mx == '0);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      if (b_cmd_r == CMD_NORM) begin
        sq_op_c[i] = item_c.mn[i];
      end else if (lane_b[i].big) begin
        sq_op_c[i] = '0;
      end else begin
        sq_op_c[i] = lane_b[i].u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_item_r <= item_c;
      sq_op_r  <= sq_op_c;
      d_item_r <= c_item_r;
    end
  end

  always_comb begin
    logic [64:0] rnd;
    sq_sum = sq_d[0] + sq_d[1] + sq_d[2];
    item_e = d_item_r;
    rnd    = ({1'b0, sq_sum} + HALF_U) >> FRAC_BITS;
    if ((d_item_r.cmd == CMD_MAGSQ) || (d_item_r.cmd == CMD_DISTSQ && !d_item_r.big)) begin
      if (rnd > 65'h0_7FFF_FFFF) begin
        item_e.scal = S32_MAX;
        item_e.sat  = 1'b1;
      end else begin
        item_e.scal = rnd[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_item_r <= item_e;
      e_sq_r   <= sq_sum;
    end
  end

  v3a_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .val  (e_sq_r),
    .root (sq_root),
    .rem  (sq_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        q_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      q_vld_r[0] <= e_vld_r;
      for (int k = 1; k < SQ_STAGES; k++) begin
        q_vld_r[k] <= q_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_item_r[0] <= e_item_r;
      for (int k = 1; k < SQ_STAGES; k++) begin
        q_item_r[k] <= q_item_r[k-1];
      end
    end
  end

  always_comb begin
    logic [32:0] rr;
    item_f = q_item_r[SQ_STAGES-1];
    rr     = {1'b0, sq_root} + 33'(sq_rem > {2'b00, sq_root});
    if ((item_f.cmd == CMD_MAG) || (item_f.cmd == CMD_DIST && !item_f.big)) begin
      if (rr[32] || rr[31]) begin
        item_f.scal = S32_MAX;
        item_f.sat  = 1'b1;
      end else begin
        item_f.scal = rr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= q_vld_r[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_item_r <= item_f;
      f_len_r  <= sq_root;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .num_mag (f_item_r.mn[i]),
      .len     (f_len_r),
      .quo     (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        g_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      g_vld_r[0] <= f_vld_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        g_vld_r[k] <= g_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_item_r[0] <= f_item_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        g_item_r[k] <= g_item_r[k-1];
      end
    end
  end

  always_comb begin
    logic [31:0] q32;
    item_t       it;
    it          = g_item_r[DIV_STAGES-1];
    out_vec_nxt = it.vec;
    q32         = '0;
    if (it.cmd == CMD_NORM && !it.zero) begin
      for (int i = 0; i < 3; i++) begin
        q32 = 32'(quo[i]);
        out_vec_nxt[i] = it.neg[i] ? (32'd0 - q32) : q32;
      end
    end
    if (it.zero) begin
      out_status_nxt = ST_ZERO;
    end else if (it.sat) begin
      out_status_nxt = ST_SAT;
    end else begin
      out_status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= g_vld_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_vec_r    <= out_vec_nxt;
      out_scal_r   <= g_item_r[DIV_STAGES-1].scal;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_r_x        = out_vec_r[0];
  assign out_r_y        = out_vec_r[1];
  assign out_r_z        = out_vec_r[2];
  assign out_scalar_out = out_scal_r;
  assign out_status     = out_status_r;

endmodule

// ===== sv/v3a_lane.sv =====
// ----------------------------------------------------------------------------
// Vector ALU lane
// Per-component sums, differences, magnitudes and products, followed by a
// registered square for the length operations.
// ----------------------------------------------------------------------------
module v3a_lane (
  input  logic               clk,
  input  logic               en,
  input  v3a_pkg::cmd_t      cmd,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] a_j,
  input  logic signed [31:0] a_k,
  input  logic signed [31:0] b_j,
  input  logic signed [31:0] b_k,
  input  logic [31:0]        sq_op,
  output v3a_pkg::lane_t     res,
  output logic [63:0]        sq
);
  import v3a_pkg::*;

  lane_t              res_r;
  lane_t              res_nxt;
  logic [63:0]        sq_r;
  logic               is_dist;
  logic signed [32:0] av;
  logic signed [32:0] dv;
  logic [32:0]        u33;
  logic [32:0]        m33;
  logic signed [31:0] mul_b;

  always_comb begin
    is_dist = (cmd == CMD_DIST) || (cmd == CMD_DISTSQ);
    av    = 33'(a_i);
    dv    = is_dist ? (33'(b_i) - av) : av;
    u33   = dv[32] ? 33'(-dv) : 33'(dv);
    m33   = av[32] ? 33'(-av) : 33'(av);
    mul_b = (cmd == CMD_CROSS) ? b_k : b_i;
    res_nxt       = '0;
    res_nxt.sum   = 33'(a_i) + 33'(b_i);
    res_nxt.dif   = 33'(a_i) - 33'(b_i);
    res_nxt.neg   = -av;
    res_nxt.u     = u33[31:0];
    res_nxt.big   = is_dist && (u33 >= 33'h0_8000_0000);
    res_nxt.m     = m33[31:0];
    res_nxt.a_neg = a_i[31];
    res_nxt.p1    = (cmd == CMD_CROSS) ? (64'(a_j) * 64'(mul_b)) : (64'(a_i) * 64'(mul_b));
    res_nxt.p2    = 64'(a_k) * 64'(b_j);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sq_r  <= 64'(sq_op) * 64'(sq_op);
    end
  end

  assign res = res_r;
  assign sq  = sq_r;

endmodule

// ===== sv/v3a_sqrt.sv =====
// ----------------------------------------------------------------------------
// Vector ALU square root
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Delivers the floor root and the remainder.
// ----------------------------------------------------------------------------
module v3a_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] val,
  output logic [31:0] root,
  output logic [33:0] rem
);
  import v3a_pkg::*;

  logic [33:0] rem_r  [SQ_STAGES];
  logic [31:0] root_r [SQ_STAGES];
  logic [63:0] v_r    [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] v_in;
    logic [35:0] r2;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = val;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign r2    = {rem_in, v_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 34'(r2 - trial) : r2[33:0];
        root_r[k] <= {root_in[30:0], ge};
        v_r[k]    <= {v_in[61:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQ_STAGES-1];
  assign rem  = rem_r[SQ_STAGES-1];

endmodule

// ===== sv/v3a_div.sv =====
// ----------------------------------------------------------------------------
// Vector ALU divider
// Pipelined restoring divider for one normalized component, one quotient
// bit per stage, rounding to nearest.
// ----------------------------------------------------------------------------
module v3a_div #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          num_mag,
  input  logic [31:0]          len,
  output logic [FRAC_BITS+1:0] quo
);
  localparam int Q  = FRAC_BITS + 2;
  localparam int NW = FRAC_BITS + 33;

  logic [NW-1:0] num;
  logic [32:0]   r_r   [Q];
  logic [Q-1:0]  lo_r  [Q];
  logic [Q-1:0]  q_r   [Q];
  logic [31:0]   len_r [Q];

  assign num = (NW'(num_mag) << FRAC_BITS) + NW'(len >> 1);

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [32:0]  r_in;
    logic [Q-1:0] lo_in;
    logic [Q-1:0] q_in;
    logic [31:0]  len_in;
    logic [33:0]  r2;
    logic [33:0]  dv;
    logic         ge;

    if (k == 0) begin : g_first
      assign r_in   = 33'(num[NW-1:Q]);
      assign lo_in  = num[Q-1:0];
      assign q_in   = '0;
      assign len_in = len;
    end else begin : g_next
      assign r_in   = r_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
      assign len_in = len_r[k-1];
    end

    assign r2 = {r_in, lo_in[Q-1]};
    assign dv = {2'b00, len_in};
    assign ge = (r2 >= dv);

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= ge ? 33'(r2 - dv) : r2[32:0];
        lo_r[k]  <= {lo_in[Q-2:0], 1'b0};
        q_r[k]   <= {q_in[Q-2:0], ge};
        len_r[k] <= len_in;
      end
    end
  end

  assign quo = q_r[Q-1];

endmodule

// ===== bench/vector3_alu_checker.sv =====
// ----------------------------------------------------------------------------
// Vector ALU checker
// Watches both channels of the vector ALU, predicts each result word from
// the accepted input word and compares it field by field, in order.
// ----------------------------------------------------------------------------
module vector3_alu_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_r_x,
  input  logic signed [31:0] out_r_y,
  input  logic signed [31:0] out_r_z,
  input  logic signed [31:0] out_scalar_out,
  input  logic [1:0]         out_status,
  output int                 fails,
  output int                 pending,
  output int                 checked
);
  import v3a_pkg::*;

  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] s;
    logic [1:0]  st;
  } vres_t;

  vres_t expected_q[$];

  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] rem, root, b2;
    rem = v;
    root = '0;
    b2 = 128'd1 << 126;
    while (b2 > v) b2 >>= 2;
    while (b2 != 0) begin
      if (rem >= root + b2) begin
        rem -= root + b2;
        root = (root >> 1) + b2;
      end else begin
        root >>= 1;
      end
      b2 >>= 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic hit);
    if (v > 128'sd2147483647) begin
      hit = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -128'sd2147483648) begin
      hit = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic vres_t predict_vector_op(
    input logic [3:0] cmd,
    input logic signed [31:0] ax, ay, az, bx, by, bz
  );
    logic signed [127:0] a[3], b[3], d, u, p, sq, mx, lim, q;
    logic signed [127:0] m[3];
    logic [31:0] r[3];
    logic [31:0] s;
    logic hit, big, zero;
    int j, k, sh;
    vres_t res;
    a[0] = 128'(ax); a[1] = 128'(ay); a[2] = 128'(az);
    b[0] = 128'(bx); b[1] = 128'(by); b[2] = 128'(bz);
    r[0] = '0; r[1] = '0; r[2] = '0;
    s = '0;
    hit = 1'b0; big = 1'b0; zero = 1'b0;
    sq = '0; mx = '0;
    lim = 128'sd2147483648;
    case (cmd)
      CMD_ADD: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] + b[i], hit);
      CMD_SUB: for (int i = 0; i < 3; i++) r[i] = clamp(a[i] - b[i], hit);
      CMD_NEG: for (int i = 0; i < 3; i++) r[i] = clamp(-a[i], hit);
      CMD_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          p = a[j] * b[k] - a[k] * b[j];
          r[i] = clamp((p + (128'sd1 <<< (FB - 1))) >>> FB, hit);
        end
      end
      CMD_DOT: begin
        p = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        s = clamp((p + (128'sd1 <<< (FB - 1))) >>> FB, hit);
      end
      CMD_MAG, CMD_MAGSQ, CMD_DIST, CMD_DISTSQ: begin
        for (int i = 0; i < 3; i++) begin
          d = (cmd == CMD_DIST || cmd == CMD_DISTSQ) ? b[i] - a[i] : a[i];
          u = (d < 0) ? -d : d;
          if (u >= lim && (cmd == CMD_DIST || cmd == CMD_DISTSQ)) big = 1'b1;
          else sq += u * u;
        end
        if (big) begin
          s = 32'h7FFF_FFFF;
          hit = 1'b1;
        end else if (cmd == CMD_MAG || cmd == CMD_DIST) begin
          p = root_floor(sq);
          if (sq - p * p > p) p += 1;
          s = clamp(p, hit);
        end else begin
          s = clamp((sq + (128'sd1 <<< (FB - 1))) >>> FB, hit);
        end
      end
      CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          m[i] = (a[i] < 0) ? -a[i] : a[i];
          if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
          zero = 1'b1;
        end else begin
          sh = 0;
          while ((mx <<< 1) <= lim) begin
            mx = mx <<< 1;
            sh++;
          end
          for (int i = 0; i < 3; i++) begin
            m[i] = m[i] <<< sh;
            sq += m[i] * m[i];
          end
          p = root_floor(sq);
          for (int i = 0; i < 3; i++) begin
            q = ((m[i] <<< FB) + (p >>> 1)) / p;
            r[i] = 32'((a[i] < 0) ? -q : q);
          end
        end
      end
      default: ;
    endcase
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    res.s = s;
    res.st = zero ? ST_ZERO : (hit ? ST_SAT : ST_OK);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    checked = 0;
  end

  assign pending = expected_q.size();

  always @(posedge clk) begin
    vres_t want;
    if (rst_n && in_valid && !in_stall)
      expected_q.push_back(predict_vector_op(in_cmd, in_a_x, in_a_y, in_a_z,
                                             in_b_x, in_b_y, in_b_z));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", out_r_x, '0);
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (out_r_x !== want.x) report_mismatch("r_x", out_r_x, want.x);
        if (out_r_y !== want.y) report_mismatch("r_y", out_r_y, want.y);
        if (out_r_z !== want.z) report_mismatch("r_z", out_r_z, want.z);
        if (out_scalar_out !== want.s) report_mismatch("scalar", out_scalar_out, want.s);
        if (out_status !== want.st) report_mismatch("status", out_status, want.st);
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Vector ALU testbench
// Drives directed corner words and then random words through the vector
// ALU under several idle and stall mixes; the checker scores every result.
// ----------------------------------------------------------------------------
module tb;
  import v3a_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         in_cmd = '0;
  logic signed [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_r_x, out_r_y, out_r_z, out_scalar_out;
  logic [1:0]         out_status;
  int                 fails, pending, checked;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 quiet_cycles = 0;

  vector3_alu_core dut (.*);

  vector3_alu_checker chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [3:0] cmd,
                           input logic [31:0] ax, ay, az, bx, by, bz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_a_x <= ax; in_a_y <= ay; in_a_z <= az;
    in_b_x <= bx; in_b_y <= by; in_b_z <= bz;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1 << 20) - (1 << 19);
      2: return $urandom_range(1 << 26) - (1 << 25);
      3: case ($urandom_range(4))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           3: return 32'h1;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return ($urandom_range(1) != 0) ? 32'h0 : $urandom_range(255);
    endcase
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NMIN = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  initial begin
    logic [3:0] cmd;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_word(CMD_ADD, PMAX, NMIN, ONE, ONE, NMIN, -ONE);
    send_word(CMD_SUB, NMIN, PMAX, 0, ONE, -1, 0);
    send_word(CMD_NEG, NMIN, PMAX, 0, 0, 0, 0);
    send_word(CMD_NEG, ONE, -ONE, 1, 0, 0, 0);
    send_word(CMD_CROSS, PMAX, NMIN, PMAX, NMIN, PMAX, NMIN);
    send_word(CMD_CROSS, ONE, 0, 0, 0, ONE, 0);
    send_word(CMD_CROSS, 1, 1, 1, 32'h8000, 32'h8000, 0);
    send_word(CMD_DOT, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN);
    send_word(CMD_DOT, 32'h8000, -32'h8000, 1, 1, 1, -32'h8000);
    send_word(CMD_DOT, ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE);
    send_word(CMD_MAG, NMIN, NMIN, NMIN, 0, 0, 0);
    send_word(CMD_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0);
    send_word(CMD_MAGSQ, PMAX, 0, 0, 0, 0, 0);
    send_word(CMD_MAGSQ, 32'h100, 0, 0, 0, 0, 0);
    send_word(CMD_DIST, NMIN, 0, 0, PMAX, 0, 0);
    send_word(CMD_DIST, 0, 0, 0, ONE, ONE, ONE);
    send_word(CMD_DISTSQ, 0, NMIN, 0, 0, 0, 0);
    send_word(CMD_DISTSQ, ONE, ONE, ONE, 2 * ONE, 0, ONE);
    send_word(CMD_NORM, 0, 0, 0, 5, 5, 5);
    send_word(CMD_NORM, NMIN, NMIN, NMIN, 0, 0, 0);
    send_word(CMD_NORM, 1, 0, -1, 0, 0, 0);
    send_word(CMD_NORM, PMAX, 1, -ONE, 0, 0, 0);
    send_word(4'd10, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX);
    send_word(4'd15, NMIN, NMIN, NMIN, NMIN, NMIN, NMIN);
    send_word(4'd12, 32'hFFFF_FFFF, 1, 2, 3, 4, 5);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      send_idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 28 : 0;
      recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 28 : 0;
      for (int n = 0; n < 500; n++) begin
        cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
        send_word(cmd, rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), rand_comp(), rand_comp());
      end
    end

    wait_drained();
    recv_stall_pct = 0;
    repeat (70) @(posedge clk);
    $display("Checked %0d result words: corner cases, all ten operations, unused codes,",
             checked);
    $display("random operands under mixed sender gaps and receiver stalls.");
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
